/* hdl/efva_pkg.sv */
// Package: shared types and constants for the earliest-free voice allocator.
package efva_pkg;

	localparam int VOICES_DEF         = 99;
	localparam int OVERFLOW_DEPTH_DEF = 1024;
	localparam int SOUND_COUNT_DEF    = 100;

	localparam logic [31:0] GUARD_MS = 32'd100;
	localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		ST_GRANTED = 2'd0,
		ST_QUEUED  = 2'd1,
		ST_DROPPED = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_WAIT,
		S_DECIDE
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_rd;
		logic finish_inv;
		logic decide;
	} dp_cmd_t;

	typedef struct packed {
		logic invalid;
		logic scan_last;
	} dp_sts_t;

endpackage

/* hdl/earliest_free_voice_allocator_unit.sv */
// Top level: earliest-free voice allocator, controller plus datapath.
// A request is taken when start is high and busy is low. A valid request
// scans the free-at times of all VOICES voices one per cycle through a single
// memory read port, then passes a wait state and a decision state before its
// done strobe; an invalid sound index answers straight from the check state,
// with no scan. Each request yields exactly one result, shown on
// status and voice for the single cycle in which done is high; the receiver
// cannot hold it off. A new request may be started in that same cycle.
module earliest_free_voice_allocator_unit #(
	parameter int VOICES         = efva_pkg::VOICES_DEF,
	parameter int OVERFLOW_DEPTH = efva_pkg::OVERFLOW_DEPTH_DEF,
	parameter int SOUND_COUNT    = efva_pkg::SOUND_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [6:0]  sound_index,
	input  logic [15:0] duration_ms,
	input  logic [31:0] now_ms,
	output logic        done,
	output logic [1:0]  status,
	output logic [6:0]  voice
);
	import efva_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	efva_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	efva_dp #(
		.VOICES         (VOICES),
		.OVERFLOW_DEPTH (OVERFLOW_DEPTH),
		.SOUND_COUNT    (SOUND_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.sound_index (sound_index),
		.duration_ms (duration_ms),
		.now_ms      (now_ms),
		.done        (done),
		.status      (status),
		.voice       (voice)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without request");

	a_grant_voice: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_GRANTED)) |-> (voice != 7'd0))
		else $error("grant without voice");

	a_nogrant_voice: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_GRANTED)) |-> (voice == 7'd0))
		else $error("voice given without grant");

endmodule

/* hdl/efva_ctrl.sv */
// Controller: sequences request check, voice scan and decision.
module efva_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output efva_pkg::dp_cmd_t cmd,
	input  efva_pkg::dp_sts_t sts
);
	import efva_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.invalid) begin
					cmd.finish_inv = 1'b1;
					state_d        = S_IDLE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	// a scan always runs to its last voice before a decision
	a_decide_after_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) |-> ($past(state_q) == S_WAIT))
		else $error("decision without finished scan");

endmodule

/* hdl/efva_dp.sv */
// Datapath: free-at time memory, overflow queue, min scan, grant/queue/drop decision, result registers.
module efva_dp #(
	parameter int VOICES         = efva_pkg::VOICES_DEF,
	parameter int OVERFLOW_DEPTH = efva_pkg::OVERFLOW_DEPTH_DEF,
	parameter int SOUND_COUNT    = efva_pkg::SOUND_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  efva_pkg::dp_cmd_t cmd,
	output efva_pkg::dp_sts_t sts,
	input  logic [6:0]        sound_index,
	input  logic [15:0]       duration_ms,
	input  logic [31:0]       now_ms,
	output logic              done,
	output logic [1:0]        status,
	output logic [6:0]        voice
);
	import efva_pkg::*;

	localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int AW = (OVERFLOW_DEPTH > 1) ? $clog2(OVERFLOW_DEPTH) : 1;
	localparam int CW = $clog2(OVERFLOW_DEPTH + 1);

	logic [6:0]    snd_q;
	logic [15:0]   dur_q;
	logic [31:0]   now_q;

	logic [31:0]   vft_mem [VOICES];
	logic [VOICES-1:0] vld_q;
	logic [6:0]    pend_mem [OVERFLOW_DEPTH];
	logic [CW-1:0] cnt_q;

	logic [IW-1:0] addr_q;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	logic [31:0]   rd_data_s1;
	logic          rd_set_s1;
	logic [31:0]   rd_val;

	logic [IW-1:0] best_idx_q;
	logic [31:0]   best_val_q;

	logic          done_q;
	status_t       status_q;
	logic [6:0]    voice_q;

	logic          voice_free;
	logic          q_full;
	logic [32:0]   t_sum;
	logic [31:0]   t_sat;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			snd_q <= sound_index;
			dur_q <= duration_ms;
			now_q <= now_ms;
		end
	end

	assign sts.invalid   = ({1'b0, snd_q} >= 8'(SOUND_COUNT));
	assign sts.scan_last = (addr_q == IW'(VOICES - 1));

	assign voice_free = !(best_val_q > now_q);
	assign q_full     = (cnt_q >= CW'(OVERFLOW_DEPTH));
	assign t_sum      = {1'b0, now_q} + {17'd0, dur_q} + {1'b0, GUARD_MS};
	assign t_sat      = t_sum[32] ? TIME_MAX : t_sum[31:0];

	// free-at time memory, one read port for the scan, one write at decision
	always_ff @(posedge clk) begin
		if (cmd.decide && voice_free) begin
			vft_mem[best_idx_q] <= t_sat;
		end
		if (cmd.scan_rd) begin
			rd_data_s1 <= vft_mem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide && !voice_free && !q_full) begin
			pend_mem[cnt_q[AW-1:0]] <= snd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			cnt_q     <= '0;
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.load) begin
				addr_q <= '0;
			end else if (cmd.scan_rd) begin
				addr_q <= addr_q + IW'(1);
			end
			if (cmd.decide) begin
				if (voice_free) begin
					vld_q[best_idx_q] <= 1'b1;
				end else if (!q_full) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			rd_idx_s1 <= addr_q;
			rd_set_s1 <= vld_q[addr_q];
		end
	end

	// unwritten entries read as zero
	assign rd_val = rd_set_s1 ? rd_data_s1 : 32'd0;

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if ((rd_idx_s1 == '0) || (rd_val < best_val_q)) begin
				best_idx_q <= rd_idx_s1;
				best_val_q <= rd_val;
			end
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.decide | cmd.finish_inv;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish_inv) begin
			status_q <= ST_INVALID;
			voice_q  <= 7'd0;
		end else if (cmd.decide) begin
			if (voice_free) begin
				status_q <= ST_GRANTED;
				voice_q  <= 7'(best_idx_q) + 7'd1;
			end else begin
				status_q <= q_full ? ST_DROPPED : ST_QUEUED;
				voice_q  <= 7'd0;
			end
		end
	end

	assign done   = done_q;
	assign status = status_q;
	assign voice  = voice_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(OVERFLOW_DEPTH))
		else $error("overflow count beyond depth");

	a_grant_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.decide && voice_free) |=> vld_q[$past(best_idx_q)])
		else $error("granted voice not marked written");

endmodule
